/* hw/rtl/plc_pkg.sv */
// shared types and constants for the password lock controller
`default_nettype none

package plc_pkg;

    // code geometry
    localparam int CODE_LEN = 5;
    localparam int CNT_W    = $clog2(CODE_LEN + 1);
    localparam int IDX_W    = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;

    // field widths
    localparam int KEY_W   = 8;
    localparam int TICK_W  = 8;
    localparam int WRONG_W = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int OUT_DATA_W = 16;

    // menu bytes
    localparam logic [KEY_W-1:0] KEY_OPEN   = 8'h2B;
    localparam logic [KEY_W-1:0] KEY_CHANGE = 8'h2D;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WRONG_LIMIT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_STOP_TICK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_START_TICK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_STOP_TICK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_END_TICK   = 3'd4;

    // configuration reset values
    localparam logic [WRONG_W-1:0] RST_WRONG_LIMIT      = 4'd3;
    localparam logic [TICK_W-1:0]  RST_OPEN_STOP_TICK   = 8'd6;
    localparam logic [TICK_W-1:0]  RST_CLOSE_START_TICK = 8'd7;
    localparam logic [TICK_W-1:0]  RST_CLOSE_STOP_TICK  = 8'd12;
    localparam logic [TICK_W-1:0]  RST_ALARM_END_TICK   = 8'd7;

    typedef enum logic [2:0] {
        MODE_CREATE     = 3'd0,
        MODE_MAIN       = 3'd1,
        MODE_OPEN_REQ   = 3'd2,
        MODE_CHANGE_REQ = 3'd3,
        MODE_DOOR       = 3'd4,
        MODE_ALARM      = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        DRV_STOP = 2'd0,
        DRV_CW   = 2'd1,
        DRV_CCW  = 2'd2
    } t_drive;

    typedef enum logic [2:0] {
        OUT_NONE     = 3'd0,
        OUT_ACCEPT   = 3'd1,
        OUT_REJECT   = 3'd2,
        OUT_STORED   = 3'd3,
        OUT_MISMATCH = 3'd4,
        OUT_ALARM    = 3'd5
    } t_outcome;

    typedef struct packed {
        logic [WRONG_W-1:0] wrong_limit;
        logic [TICK_W-1:0]  open_stop_tick;
        logic [TICK_W-1:0]  close_start_tick;
        logic [TICK_W-1:0]  close_stop_tick;
        logic [TICK_W-1:0]  alarm_end_tick;
    } t_cfg;

    // mode sits in the lowest bits
    typedef struct packed {
        t_outcome outcome;
        logic     siren_on;
        t_drive   motor_drive;
        t_mode    app_state;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

`default_nettype wire

/* hw/rtl/plc_engine.sv */
// lock state registers and the per-beat next-state logic
`default_nettype none

module plc_engine (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic                        i_cmd,
    input  wire logic [plc_pkg::KEY_W-1:0]   i_key,
    input  wire plc_pkg::t_cfg               i_cfg,
    output plc_pkg::t_result                 o_result
);
    import plc_pkg::*;

    // control state
    t_mode               r_mode,   n_mode;
    t_drive              r_drive,  n_drive;
    logic                r_buzzer, n_buzzer;
    logic [CNT_W-1:0]    r_idx,    n_idx;
    logic                r_phase,  n_phase;
    logic                r_mis,    n_mis;
    logic [WRONG_W-1:0]  r_wrong,  n_wrong;
    logic [TICK_W-1:0]   r_tick,   n_tick;

    // code digits: written during creation, compared during checks
    logic [KEY_W-1:0]    r_code [CODE_LEN];

    logic                code_we;
    logic [IDX_W-1:0]    digit;
    logic [CNT_W-1:0]    idx_inc;
    logic                last_digit;
    logic                mis;
    logic [TICK_W-1:0]   tick_inc;
    logic [WRONG_W-1:0]  wrong_inc;
    t_outcome            outcome;

    assign digit      = r_idx[IDX_W-1:0];
    assign idx_inc    = r_idx + 1'b1;
    assign last_digit = (idx_inc == CNT_W'(CODE_LEN));
    assign mis        = r_mis | (r_code[digit] != i_key);
    assign tick_inc   = r_tick + 1'b1;
    assign wrong_inc  = r_wrong + 1'b1;

    // next state for one beat
    always_comb begin
        n_mode   = r_mode;
        n_drive  = r_drive;
        n_buzzer = r_buzzer;
        n_idx    = r_idx;
        n_phase  = r_phase;
        n_mis    = r_mis;
        n_wrong  = r_wrong;
        n_tick   = r_tick;
        code_we  = 1'b0;
        outcome  = OUT_NONE;

        if (i_cmd) begin
            // timer tick drives the door and alarm sequences
            case (r_mode)
                MODE_DOOR: begin
                    n_tick = tick_inc;
                    if (tick_inc == i_cfg.close_stop_tick) begin
                        n_drive = DRV_STOP;
                        n_tick  = '0;
                        n_mode  = MODE_MAIN;
                    end else if (tick_inc == i_cfg.close_start_tick) begin
                        n_drive = DRV_CCW;
                    end else if (tick_inc == i_cfg.open_stop_tick) begin
                        n_drive = DRV_STOP;
                    end else if (tick_inc == TICK_W'(1)) begin
                        n_drive = DRV_CW;
                    end
                end
                MODE_ALARM: begin
                    n_tick = tick_inc;
                    if (tick_inc == i_cfg.alarm_end_tick) begin
                        n_buzzer = 1'b0;
                        n_tick   = '0;
                        n_mode   = MODE_MAIN;
                    end else if (tick_inc == TICK_W'(1)) begin
                        n_buzzer = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end else begin
            case (r_mode)
                // digit then its re-entry
                MODE_CREATE: begin
                    if (!r_phase) begin
                        code_we = 1'b1;
                        n_phase = 1'b1;
                    end else begin
                        n_phase = 1'b0;
                        if (!last_digit) begin
                            n_idx = idx_inc;
                            n_mis = mis;
                        end else begin
                            n_idx = '0;
                            n_mis = 1'b0;
                            if (!mis) begin
                                n_mode  = MODE_MAIN;
                                outcome = OUT_STORED;
                            end else begin
                                outcome = OUT_MISMATCH;
                            end
                        end
                    end
                end
                // menu selection
                MODE_MAIN: begin
                    if (i_key == KEY_OPEN) begin
                        n_mode  = MODE_OPEN_REQ;
                        n_idx   = '0;
                        n_phase = 1'b0;
                        n_mis   = 1'b0;
                    end else if (i_key == KEY_CHANGE) begin
                        n_mode  = MODE_CHANGE_REQ;
                        n_idx   = '0;
                        n_phase = 1'b0;
                        n_mis   = 1'b0;
                    end
                end
                // code check against the stored digits
                MODE_OPEN_REQ, MODE_CHANGE_REQ: begin
                    if (!last_digit) begin
                        n_idx = idx_inc;
                        n_mis = mis;
                    end else begin
                        n_idx   = '0;
                        n_phase = 1'b0;
                        n_mis   = 1'b0;
                        if (!mis) begin
                            n_wrong = '0;
                            outcome = OUT_ACCEPT;
                            if (r_mode == MODE_OPEN_REQ) begin
                                n_mode  = MODE_DOOR;
                                n_tick  = '0;
                                n_drive = DRV_STOP;
                            end else begin
                                n_mode = MODE_CREATE;
                            end
                        end else if (wrong_inc >= i_cfg.wrong_limit) begin
                            n_wrong  = '0;
                            n_mode   = MODE_ALARM;
                            n_tick   = '0;
                            n_buzzer = 1'b0;
                            outcome  = OUT_ALARM;
                        end else begin
                            n_wrong = wrong_inc;
                            outcome = OUT_REJECT;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // state registers advance only on a processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_CREATE;
            r_drive  <= DRV_STOP;
            r_buzzer <= 1'b0;
            r_idx    <= '0;
            r_phase  <= 1'b0;
            r_mis    <= 1'b0;
            r_wrong  <= '0;
            r_tick   <= '0;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_drive  <= n_drive;
            r_buzzer <= n_buzzer;
            r_idx    <= n_idx;
            r_phase  <= n_phase;
            r_mis    <= n_mis;
            r_wrong  <= n_wrong;
            r_tick   <= n_tick;
        end
    end

    // code digit storage
    always_ff @(posedge i_clk) begin
        if (i_step && code_we) begin
            r_code[digit] <= i_key;
        end
    end

    // result reflects the state after this beat
    always_comb begin
        o_result.app_state   = n_mode;
        o_result.motor_drive = n_drive;
        o_result.siren_on    = n_buzzer;
        o_result.outcome     = outcome;
    end

endmodule

`default_nettype wire

/* hw/rtl/password_lock_controller.sv */
// top level of the keypad password lock controller
// a beat is held in the input register, then its result in the result register
// throughput: one beat per cycle unless the master stalls, key bytes and timer ticks alike
// while a result waits on the master side the input register takes one more beat, then stalls
// reset (i_rst_n low, synchronous): create mode, motor stopped, buzzer off, counters zero,
// configuration back to limit 3 and ticks 6, 7, 12, 7
`default_nettype none

module password_lock_controller (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [plc_pkg::KEY_W-1:0]        s_axis_tdata,  // [7:0] key_byte
    input  wire logic                             s_axis_tuser,  // [0] cmd
    // result stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [2:0] app_state, [4:3] motor_drive, [5] siren_on, [8:6] outcome, [15:9] zero
    output logic [plc_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [plc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [plc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import plc_pkg::*;

    t_cfg                r_cfg;
    logic                r_in_valid;
    logic                r_in_cmd;
    logic [KEY_W-1:0]    r_in_key;
    logic                r_out_valid;
    t_result             r_out;
    t_result             result;
    logic                advance;

    // process the held beat when the result slot is free or draining
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wrong_limit      <= RST_WRONG_LIMIT;
            r_cfg.open_stop_tick   <= RST_OPEN_STOP_TICK;
            r_cfg.close_start_tick <= RST_CLOSE_START_TICK;
            r_cfg.close_stop_tick  <= RST_CLOSE_STOP_TICK;
            r_cfg.alarm_end_tick   <= RST_ALARM_END_TICK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WRONG_LIMIT:      r_cfg.wrong_limit      <= i_cfg_data[WRONG_W-1:0];
                CFG_OPEN_STOP_TICK:   r_cfg.open_stop_tick   <= i_cfg_data[TICK_W-1:0];
                CFG_CLOSE_START_TICK: r_cfg.close_start_tick <= i_cfg_data[TICK_W-1:0];
                CFG_CLOSE_STOP_TICK:  r_cfg.close_stop_tick  <= i_cfg_data[TICK_W-1:0];
                CFG_ALARM_END_TICK:   r_cfg.alarm_end_tick   <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cmd <= s_axis_tuser;
            r_in_key <= s_axis_tdata;
        end
    end

    plc_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_cmd    (r_in_cmd),
        .i_key    (r_in_key),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, r_out};

endmodule

`default_nettype wire
